// ===== design/knpt_pkg.sv =====
// ----------------------------------------------------------------------------
// knpt_pkg
// Types and constants shared by the k-nearest point tracker modules.
// ----------------------------------------------------------------------------
package knpt_pkg;

  localparam int MAX_KEEP_DEF = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int KEEP_W       = 7;
  localparam int COORD_W      = 16;
  localparam int DIST_W       = 32;

  // command codes on the input channel
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] far_x;
    logic signed [COORD_W-1:0] far_y;
    logic [KEEP_W-1:0]         count_held;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_REPORT
  } op_t;

  // classified work item as held in the queue
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         dist_sq;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } push_t;

endpackage

// ===== design/k_nearest_point_tracker.sv =====
// ----------------------------------------------------------------------------
// k_nearest_point_tracker
// Keeps the k points nearest the origin, ranked by squared distance, x, y.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a command beat is taken on a clock edge with start high and busy
//   low. cmd 0 clears the store, 1 inserts, 2 inserts and reports, 3 is
//   dropped. busy rises once four beats are in flight across the two
//   distance stages and the four-entry work queue together.
//   Output: a report gives one beat, out_strobe high for one cycle, with the
//   farthest held point and the count held. The receiver cannot stall.
//   Config: cfg_we writes keep_count (k) from cfg_wdata; write only when idle.
//   0 acts as 1, values above MAX_KEEP act as MAX_KEEP.
//   Report path: a report passes the two distance stages, the queue and one
//   chain update before it strobes, and waits longer if work is queued.
//   Throughput: one beat per cycle while busy is low. Each point dropped
//   after k was lowered below the fill costs one shift of the chain.
//   Reset: store empty, k = 1, queue empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module k_nearest_point_tracker #(
  parameter int MAX_KEEP = knpt_pkg::MAX_KEEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  knpt_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output knpt_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [knpt_pkg::KEEP_W-1:0] cfg_wdata
);
  import knpt_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [KEEP_W-1:0] keep_count_r;
  push_t             push;
  logic              head_valid;
  work_t             head;
  logic [QCW-1:0]    q_count;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_W'(1);
    end else if (cfg_we) begin
      keep_count_r <= cfg_wdata;
    end
  end

  knpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .q_count (q_count),
    .busy    (busy),
    .push    (push)
  );

  knpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  knpt_chain #(
    .MAX_KEEP (MAX_KEEP)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .keep_count (keep_count_r),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== design/knpt_front.sv =====
// ----------------------------------------------------------------------------
// knpt_front
// Takes command beats, drops unknown commands, computes the squared distance
// over two registered stages and pushes the classified work into the queue.
// ----------------------------------------------------------------------------
module knpt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  knpt_pkg::in_item_t in_item,
  input  logic [$clog2(knpt_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic               busy,
  output knpt_pkg::push_t    push
);
  import knpt_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic                      s1_v_r, s1_v_nxt;
  op_t                       s1_op_r, s1_op_nxt;
  logic signed [COORD_W-1:0] s1_x_r, s1_y_r;
  logic [DIST_W-1:0]         s1_sqx_r, s1_sqy_r;
  logic                      s2_v_r;
  work_t                     s2_work_r;

  logic signed [DIST_W-1:0]  px_w, py_w;
  logic [QCW:0]              fill;
  logic                      accept;

  assign fill   = (QCW+1)'(q_count) + (QCW+1)'(s1_v_r) + (QCW+1)'(s2_v_r);
  assign busy   = (fill >= (QCW+1)'(QUEUE_DEPTH));
  assign accept = start && !busy;

  assign px_w = DIST_W'(in_item.point_x);
  assign py_w = DIST_W'(in_item.point_y);

  always_comb begin
    s1_v_nxt  = 1'b0;
    s1_op_nxt = OP_INSERT;
    unique case (in_item.cmd)
      CMD_CLEAR: begin
        s1_v_nxt  = accept;
        s1_op_nxt = OP_CLEAR;
      end
      CMD_INSERT: begin
        s1_v_nxt  = accept;
        s1_op_nxt = OP_INSERT;
      end
      CMD_REPORT: begin
        s1_v_nxt  = accept;
        s1_op_nxt = OP_REPORT;
      end
      default: begin
        // unknown command: swallowed here, no effect downstream
        s1_v_nxt  = 1'b0;
        s1_op_nxt = OP_INSERT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s1_v_r;
    end
    s1_op_r           <= s1_op_nxt;
    s1_x_r            <= in_item.point_x;
    s1_y_r            <= in_item.point_y;
    s1_sqx_r          <= DIST_W'(px_w * px_w);
    s1_sqy_r          <= DIST_W'(py_w * py_w);
    s2_work_r.op      <= s1_op_r;
    s2_work_r.x       <= s1_x_r;
    s2_work_r.y       <= s1_y_r;
    s2_work_r.dist_sq <= s1_sqx_r + s1_sqy_r;
  end

  assign push.valid = s2_v_r;
  assign push.work  = s2_work_r;

endmodule

// ===== design/knpt_queue.sv =====
// ----------------------------------------------------------------------------
// knpt_queue
// Short FIFO of classified work between the front and the sorted chain.
// ----------------------------------------------------------------------------
module knpt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  knpt_pkg::push_t push,
  input  logic            pop,
  output logic            head_valid,
  output knpt_pkg::work_t head,
  output logic [$clog2(knpt_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import knpt_pkg::*;

  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  work_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCW'(push.valid) - QCW'(do_pop);
    end
    if (push.valid) begin
      slots_r[wr_ptr_r] <= push.work;
    end
  end

endmodule

// ===== design/knpt_chain.sv =====
// ----------------------------------------------------------------------------
// knpt_chain
// Sorted chain of point cells, farthest first. Every cell compares the new
// point with its own entry and picks its next value from itself, a
// neighbour or the new point, so an insert lands in a single update.
// ----------------------------------------------------------------------------
module knpt_chain #(
  parameter int MAX_KEEP = knpt_pkg::MAX_KEEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  knpt_pkg::work_t            head,
  input  logic [knpt_pkg::KEEP_W-1:0] keep_count,
  output logic                       pop,
  output logic                       out_strobe,
  output knpt_pkg::out_item_t        out_item
);
  import knpt_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         d;
  } cell_t;

  cell_t          cells_r [MAX_KEEP];
  cell_t          cells_nxt [MAX_KEEP];
  logic [CW-1:0]  held_r, held_nxt;
  logic           rep_r, rep_nxt;
  logic [CW-1:0]  eff_k;
  logic [MAX_KEEP-1:0] gt;
  cell_t          pnew;
  logic           act_shift, act_ins, act_rep;

  // new point ranks strictly below a held one
  function automatic logic ranks_below(cell_t a, cell_t b);
    logic r;
    if (a.d != b.d)      r = (a.d < b.d);
    else if (a.x != b.x) r = (a.x < b.x);
    else                 r = (a.y < b.y);
    return r;
  endfunction

  always_comb begin
    if (keep_count == '0) begin
      eff_k = CW'(1);
    end else if (32'(keep_count) > 32'(MAX_KEEP)) begin
      eff_k = CW'(MAX_KEEP);
    end else begin
      eff_k = CW'(keep_count);
    end
  end

  assign pnew.x = head.x;
  assign pnew.y = head.y;
  assign pnew.d = head.dist_sq;

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      gt[i] = (i < int'(held_r)) && ranks_below(pnew, cells_r[i]);
    end
  end

  // k lowered below the fill: drop the farthest, one per cycle, before inserting
  assign act_shift = head_valid && (head.op != OP_CLEAR) && (held_r > eff_k);
  assign act_ins   = head_valid && (head.op != OP_CLEAR) && (held_r < eff_k);
  assign act_rep   = head_valid && (head.op != OP_CLEAR) && (held_r == eff_k) && gt[0];
  assign pop       = head_valid && !act_shift;

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    cell_t up_c, dn_c;
    logic  up_gt, dn_gt;

    if (g == MAX_KEEP - 1) begin : g_last
      assign up_c  = cells_r[g];
      assign up_gt = 1'b0;
    end else begin : g_mid
      assign up_c  = cells_r[g+1];
      assign up_gt = gt[g+1];
    end
    if (g == 0) begin : g_first
      assign dn_c  = pnew;
      assign dn_gt = 1'b1;
    end else begin : g_rest
      assign dn_c  = cells_r[g-1];
      assign dn_gt = gt[g-1];
    end

    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (act_shift) begin
        cells_nxt[g] = up_c;
      end else if (act_ins) begin
        if (gt[g])      cells_nxt[g] = cells_r[g];
        else if (dn_gt) cells_nxt[g] = pnew;
        else            cells_nxt[g] = dn_c;
      end else if (act_rep) begin
        if (up_gt)      cells_nxt[g] = up_c;
        else if (gt[g]) cells_nxt[g] = pnew;
        else            cells_nxt[g] = cells_r[g];
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (head_valid && head.op == OP_CLEAR) begin
      held_nxt = '0;
    end else if (act_shift) begin
      held_nxt = held_r - 1'b1;
    end else if (act_ins) begin
      held_nxt = held_r + 1'b1;
    end
    rep_nxt = pop && (head.op == OP_REPORT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      rep_r  <= 1'b0;
    end else begin
      held_r <= held_nxt;
      rep_r  <= rep_nxt;
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  // farthest point sits in the first cell once the update has landed
  assign out_strobe          = rep_r;
  assign out_item.far_x      = cells_r[0].x;
  assign out_item.far_y      = cells_r[0].y;
  assign out_item.count_held = KEEP_W'(held_r);

endmodule

// ===== test/k_nearest_point_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// k_nearest_point_tracker_tb
// Self-checking bench: a directed table, then random phases with a range of
// keep counts. A software copy of the tracker predicts every report beat of untyped rows.
// ----------------------------------------------------------------------------
module k_nearest_point_tracker_tb;
  import knpt_pkg::*;

  localparam int TRACK_MAX = MAX_KEEP_DEF;
  localparam int SETTLE    = 100;

  typedef struct {
    bit              is_cfg;
    logic [6:0]      k_val;
    in_item_t        item;
    bit              typed;
    out_item_t       want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_we;
  logic [KEEP_W-1:0] cfg_wdata;

  // tracker copy used for prediction
  logic signed [COORD_W-1:0] kept_x [TRACK_MAX];
  logic signed [COORD_W-1:0] kept_y [TRACK_MAX];
  int          kept_n;
  logic [6:0]  keep_reg;

  out_item_t   report_q [$];
  int          err_count;
  stim_row_t   dir_tbl [25];

  k_nearest_point_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [31:0] sq_dist(logic signed [15:0] x, logic signed [15:0] y);
    int sx, sy;
    logic [31:0] px, py;
    sx = x;
    sy = y;
    px = sx * sx;
    py = sy * sy;
    return px + py;
  endfunction

  function automatic bit ranks_below(logic signed [15:0] ax, logic signed [15:0] ay,
                                     logic signed [15:0] bx, logic signed [15:0] by);
    logic [31:0] da, db;
    da = sq_dist(ax, ay);
    db = sq_dist(bx, by);
    if (da != db) return da < db;
    if (ax != bx) return ax < bx;
    return ay < by;
  endfunction

  function automatic int far_idx();
    int best;
    best = 0;
    for (int i = 1; i < kept_n; i++)
      if (ranks_below(kept_x[best], kept_y[best], kept_x[i], kept_y[i])) best = i;
    return best;
  endfunction

  task automatic predict_beat(input in_item_t it, output bit has, output out_item_t r);
    int k, f;
    has = 1'b0;
    r   = '0;
    case (it.cmd)
      CMD_CLEAR: kept_n = 0;
      CMD_INSERT, CMD_REPORT: begin
        k = int'(keep_reg);
        if (k == 0) k = 1;
        if (k > TRACK_MAX) k = TRACK_MAX;
        // k lowered under the fill: shed the farthest first
        while (kept_n > k) begin
          f = far_idx();
          kept_x[f] = kept_x[kept_n-1];
          kept_y[f] = kept_y[kept_n-1];
          kept_n--;
        end
        if (kept_n < k) begin
          kept_x[kept_n] = it.point_x;
          kept_y[kept_n] = it.point_y;
          kept_n++;
        end else begin
          f = far_idx();
          if (ranks_below(it.point_x, it.point_y, kept_x[f], kept_y[f])) begin
            kept_x[f] = it.point_x;
            kept_y[f] = it.point_y;
          end
        end
        if (it.cmd == CMD_REPORT) begin
          f = far_idx();
          has          = 1'b1;
          r.far_x      = kept_x[f];
          r.far_y      = kept_y[f];
          r.count_held = kept_n[KEEP_W-1:0];
        end
      end
      default: ;
    endcase
  endtask

  // holds start and the item until the block takes the beat
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    bit has;
    out_item_t r;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(it, has, r);
    if (has) report_q.push_back(typed ? want : r);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic set_keep(input logic [6:0] v);
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    // quiet inserts may still be in the chain
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    keep_reg = v;
  endtask

  function automatic stim_row_t beat_row(logic [1:0] cmd, logic signed [15:0] x,
                                         logic signed [15:0] y);
    stim_row_t s;
    s.is_cfg       = 1'b0;
    s.k_val        = '0;
    s.item.cmd     = cmd;
    s.item.point_x = x;
    s.item.point_y = y;
    s.typed        = 1'b0;
    s.want         = '0;
    return s;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] cmd, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] ex,
                                          logic signed [15:0] ey, logic [6:0] en);
    stim_row_t s;
    s = beat_row(cmd, x, y);
    s.typed           = 1'b1;
    s.want.far_x      = ex;
    s.want.far_y      = ey;
    s.want.count_held = en;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [6:0] v);
    stim_row_t s;
    s = beat_row(CMD_NOP, 0, 0);
    s.is_cfg = 1'b1;
    s.k_val  = v;
    return s;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 40)) - 20);
      2: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [6:0] rand_keep();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 126));
      4: return 7'($urandom_range(9, 63));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  // result checker: the receiver never stalls, so every strobe is a beat
  always @(posedge clk) begin : chk
    out_item_t w;
    if (rst_n && out_strobe) begin
      if (report_q.size() == 0) begin
        err_count++;
        $display("%0t unexpected report beat far_x %0d far_y %0d count %0d", $time,
                 out_item.far_x, out_item.far_y, out_item.count_held);
      end else begin
        w = report_q.pop_front();
        if (out_item.far_x !== w.far_x) begin
          err_count++;
          $display("%0t far_x expected %0d actual %0d", $time, w.far_x, out_item.far_x);
        end
        if (out_item.far_y !== w.far_y) begin
          err_count++;
          $display("%0t far_y expected %0d actual %0d", $time, w.far_y, out_item.far_y);
        end
        if (out_item.count_held !== w.count_held) begin
          err_count++;
          $display("%0t count_held expected %0d actual %0d", $time, w.count_held,
                   out_item.count_held);
        end
      end
    end
  end

  initial begin : stim
    stim_row_t row;
    in_item_t  it;
    int        burst_left;
    int        r;
    bit        no_idle;
    int        waited;

    err_count = 0;
    kept_n    = 0;
    keep_reg  = 7'd1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;

    dir_tbl[0]  = typed_row(CMD_REPORT, 5, -3, 5, -3, 1);
    dir_tbl[1]  = typed_row(CMD_REPORT, -32768, -32768, 5, -3, 1);
    dir_tbl[2]  = typed_row(CMD_REPORT, 0, 0, 0, 0, 1);
    dir_tbl[3]  = beat_row(CMD_NOP, 7, 7);
    dir_tbl[4]  = typed_row(CMD_REPORT, 0, 0, 0, 0, 1);
    dir_tbl[5]  = beat_row(CMD_CLEAR, -1, -1);
    dir_tbl[6]  = typed_row(CMD_REPORT, 32767, 32767, 32767, 32767, 1);
    dir_tbl[7]  = typed_row(CMD_REPORT, -32768, 32767, 32767, 32767, 1);
    dir_tbl[8]  = beat_row(CMD_CLEAR, 0, 0);
    // equal distance: x decides, then y
    dir_tbl[9]  = typed_row(CMD_REPORT, 4, 3, 4, 3, 1);
    dir_tbl[10] = typed_row(CMD_REPORT, -3, 4, -3, 4, 1);
    dir_tbl[11] = typed_row(CMD_REPORT, -3, -4, -3, -4, 1);
    dir_tbl[12] = cfg_row(7'd3);
    dir_tbl[13] = beat_row(CMD_INSERT, 1, 1);
    dir_tbl[14] = beat_row(CMD_REPORT, -2, 0);
    dir_tbl[15] = beat_row(CMD_REPORT, 0, 1);
    // zero acts as one and sheds the extra points
    dir_tbl[16] = cfg_row(7'd0);
    dir_tbl[17] = beat_row(CMD_REPORT, 9, 9);
    dir_tbl[18] = cfg_row(7'd127);
    dir_tbl[19] = beat_row(CMD_REPORT, -32768, -32768);
    dir_tbl[20] = beat_row(CMD_REPORT, 32767, -32768);
    dir_tbl[21] = cfg_row(7'd64);
    dir_tbl[22] = beat_row(CMD_INSERT, -1, -1);
    dir_tbl[23] = beat_row(CMD_REPORT, -1, -1);
    dir_tbl[24] = beat_row(CMD_CLEAR, 32767, 32767);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.is_cfg) set_keep(row.k_val);
      else begin
        send_beat(row.item, row.typed, row.want);
        pause($urandom_range(0, 2));
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 1) == 0) begin
        it.cmd     = CMD_CLEAR;
        it.point_x = 16'($urandom);
        it.point_y = 16'($urandom);
        send_beat(it, 1'b0, '0);
      end
      set_keep(rand_keep());
      no_idle    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < 85; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2)       it.cmd = CMD_CLEAR;
        else if (r < 6)  it.cmd = CMD_NOP;
        else if (r < 55) it.cmd = CMD_INSERT;
        else             it.cmd = CMD_REPORT;
        it.point_x = rand_coord();
        it.point_y = rand_coord();
        send_beat(it, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          if (!no_idle) pause($urandom_range(0, 8));
          burst_left = $urandom_range(1, 16);
        end
      end
    end

    start <= 1'b0;
    waited = 0;
    while (report_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (report_q.size() != 0) begin
      err_count += report_q.size();
      $display("%0t %0d report beats never arrived", $time, report_q.size());
    end
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/knpt_pkg.sv
design/knpt_front.sv
design/knpt_queue.sv
design/knpt_chain.sv
design/k_nearest_point_tracker.sv
test/k_nearest_point_tracker_tb.sv
